@@ sv/box_pair_vote_argmax_matcher_macros.svh @@
// ----------------------------------------------------------------------------
// Box pair vote matcher assertion macros
// Shared assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BOX_PAIR_VOTE_ARGMAX_MATCHER_MACROS_SVH
`define BOX_PAIR_VOTE_ARGMAX_MATCHER_MACROS_SVH

// check a property at every rising clock edge out of reset
`define BPVAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition never holds out of reset
`define BPVAM_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ sv/bpvam_pkg.sv @@
// ----------------------------------------------------------------------------
// Box pair vote matcher package
// Opcodes, result widths and parameter defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpvam_pkg;

  localparam int MAX_BOXES_DEF  = 32;
  localparam int COUNT_BITS_DEF = 16;

  localparam int LABEL_BITS   = 8;
  localparam int OUT_ID_BITS  = 5;
  localparam int OUT_CNT_BITS = 16;

  localparam logic OP_COUNT  = 1'b0;
  localparam logic OP_FINISH = 1'b1;

endpackage

@@ sv/box_pair_vote_argmax_matcher.sv @@
// ----------------------------------------------------------------------------
// Box pair vote matcher
// Counts votes per (previous box, current box) pair and reports, per previous
// box, the current box with the most votes.
// ----------------------------------------------------------------------------
// A count item (op 0) keeps busy high for 1 cycle: the vote table is read in
// the transfer cycle and written back in the next. An ignored match (label of
// MAX_BOXES or more, or no lidar) is dropped at once and busy stays low. A
// finish item (op 1) walks the whole table, one counter per cycle, and holds
// busy high throughout; each row with votes gives one result on result_valid_o,
// shown for one cycle once the next such row closes or the walk ends, and the
// run ends with last_o in the first cycle with busy low again. The walk zeroes
// each counter behind it. After reset a clearing pass zeroes the table with
// busy high. The receiver cannot stall: every result must be taken in its
// strobe cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "box_pair_vote_argmax_matcher_macros.svh"

module box_pair_vote_argmax_matcher
  import bpvam_pkg::*;
#(
  parameter int MAX_BOXES  = MAX_BOXES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    op_i,
  input  logic [LABEL_BITS-1:0]   prev_label_i,
  input  logic [LABEL_BITS-1:0]   curr_label_i,
  input  logic                    curr_has_lidar_i,
  output logic                    result_valid_o,
  output logic [OUT_ID_BITS-1:0]  source_box_o,
  output logic [OUT_ID_BITS-1:0]  best_box_o,
  output logic [OUT_CNT_BITS-1:0] vote_count_o,
  output logic                    found_o,
  output logic                    last_o
);

  localparam int IDW   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int DEPTH = MAX_BOXES * MAX_BOXES;
  localparam int AW    = $clog2(DEPTH);
  localparam int IDX   = (IDW > OUT_ID_BITS) ? IDW : OUT_ID_BITS;
  localparam int CXW   = (COUNT_BITS > OUT_CNT_BITS) ? COUNT_BITS : OUT_CNT_BITS;

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CNT   = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;

  localparam logic [IDW-1:0] ID_LAST = IDW'(MAX_BOXES - 1);

  logic [COUNT_BITS-1:0] mem [DEPTH];

  logic [2:0]            state_q, state_d;
  logic [IDW-1:0]        p_q, p_d, c_q, c_d;
  logic [AW-1:0]         cnt_addr_q, cnt_addr_d;
  logic [COUNT_BITS-1:0] rd_data_q;
  logic                  sw_vld_q;
  logic [IDW-1:0]        sw_p_q, sw_c_q;
  logic [AW-1:0]         sw_addr_q;
  logic [COUNT_BITS-1:0] top_q, top_d;
  logic [IDW-1:0]        best_q, best_d;
  logic                  pend_vld_q, pend_vld_d;
  logic [IDW-1:0]        pend_src_q, pend_src_d, pend_best_q, pend_best_d;
  logic [COUNT_BITS-1:0] pend_cnt_q, pend_cnt_d;

  logic                  out_vld_q, out_vld_d;
  logic [IDW-1:0]        out_src_q, out_src_d, out_best_q, out_best_d;
  logic [COUNT_BITS-1:0] out_cnt_q, out_cnt_d;
  logic                  out_found_q, out_found_d, out_last_q, out_last_d;

  logic                  accept, match_ok;
  logic                  rd_en, we;
  logic [AW-1:0]         rd_addr, wr_addr, pc_addr, in_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic [COUNT_BITS-1:0] row_top;
  logic [IDW-1:0]        row_best;
  logic [IDX-1:0]        src_ext, best_ext;
  logic [CXW-1:0]        cnt_ext;

  assign accept   = start && !busy;
  assign match_ok = (prev_label_i < LABEL_BITS'(MAX_BOXES)) &&
                    (curr_label_i < LABEL_BITS'(MAX_BOXES)) && curr_has_lidar_i;
  assign pc_addr  = AW'(p_q) * AW'(MAX_BOXES) + AW'(c_q);
  assign in_addr  = AW'(IDW'(prev_label_i)) * AW'(MAX_BOXES) + AW'(IDW'(curr_label_i));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = pc_addr;
    if (accept && op_i == OP_COUNT && match_ok) begin
      rd_en   = 1'b1;
      rd_addr = in_addr;
    end else if (state_q == ST_SWEEP) begin
      rd_en = 1'b1;
    end
  end

  always_comb begin
    we      = 1'b0;
    wr_addr = pc_addr;
    wr_data = '0;
    if (state_q == ST_CLR) begin
      we = 1'b1;
    end else if (state_q == ST_CNT) begin
      we      = 1'b1;
      wr_addr = cnt_addr_q;
      wr_data = (rd_data_q == {COUNT_BITS{1'b1}}) ? rd_data_q : rd_data_q + 1'b1;
    end else if (sw_vld_q) begin
      we      = 1'b1;
      wr_addr = sw_addr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
    sw_p_q    <= p_q;
    sw_c_q    <= c_q;
    sw_addr_q <= pc_addr;
  end

  always_comb begin
    row_top  = top_q;
    row_best = best_q;
    if (sw_c_q == '0) begin
      row_top  = rd_data_q;
      row_best = '0;
    end else if (rd_data_q > top_q) begin
      row_top  = rd_data_q;
      row_best = sw_c_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    p_d         = p_q;
    c_d         = c_q;
    cnt_addr_d  = cnt_addr_q;
    top_d       = top_q;
    best_d      = best_q;
    pend_vld_d  = pend_vld_q;
    pend_src_d  = pend_src_q;
    pend_best_d = pend_best_q;
    pend_cnt_d  = pend_cnt_q;
    out_vld_d   = 1'b0;
    out_src_d   = out_src_q;
    out_best_d  = out_best_q;
    out_cnt_d   = out_cnt_q;
    out_found_d = out_found_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      ST_CLR, ST_SWEEP: begin
        c_d = c_q + 1'b1;
        if (c_q == ID_LAST) begin
          c_d = '0;
          p_d = p_q + 1'b1;
          if (p_q == ID_LAST) begin
            p_d     = '0;
            state_d = (state_q == ST_CLR) ? ST_IDLE : ST_DRAIN;
          end
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (op_i == OP_FINISH) begin
            state_d    = ST_SWEEP;
            p_d        = '0;
            c_d        = '0;
            pend_vld_d = 1'b0;
          end else if (match_ok) begin
            state_d    = ST_CNT;
            cnt_addr_d = in_addr;
          end
        end
      end
      ST_CNT: begin
        state_d = ST_IDLE;
      end
      ST_DRAIN: begin
        state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        state_d     = ST_IDLE;
        out_vld_d   = 1'b1;
        out_last_d  = 1'b1;
        out_found_d = pend_vld_q;
        out_src_d   = pend_vld_q ? pend_src_q : '0;
        out_best_d  = pend_vld_q ? pend_best_q : '0;
        out_cnt_d   = pend_vld_q ? pend_cnt_q : '0;
        pend_vld_d  = 1'b0;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (sw_vld_q) begin
      top_d  = row_top;
      best_d = row_best;
      if (sw_c_q == ID_LAST && row_top != '0) begin
        if (pend_vld_q) begin
          out_vld_d   = 1'b1;
          out_last_d  = 1'b0;
          out_found_d = 1'b1;
          out_src_d   = pend_src_q;
          out_best_d  = pend_best_q;
          out_cnt_d   = pend_cnt_q;
        end
        pend_vld_d  = 1'b1;
        pend_src_d  = sw_p_q;
        pend_best_d = row_best;
        pend_cnt_d  = row_top;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLR;
      p_q        <= '0;
      c_q        <= '0;
      sw_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      p_q        <= p_d;
      c_q        <= c_d;
      sw_vld_q   <= (state_q == ST_SWEEP);
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_addr_q  <= cnt_addr_d;
    top_q       <= top_d;
    best_q      <= best_d;
    pend_src_q  <= pend_src_d;
    pend_best_q <= pend_best_d;
    pend_cnt_q  <= pend_cnt_d;
    out_src_q   <= out_src_d;
    out_best_q  <= out_best_d;
    out_cnt_q   <= out_cnt_d;
    out_found_q <= out_found_d;
    out_last_q  <= out_last_d;
  end

  assign src_ext  = IDX'(out_src_q);
  assign best_ext = IDX'(out_best_q);
  assign cnt_ext  = CXW'(out_cnt_q);

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = out_vld_q;
  assign source_box_o   = src_ext[OUT_ID_BITS-1:0];
  assign best_box_o     = best_ext[OUT_ID_BITS-1:0];
  assign vote_count_o   = (cnt_ext > CXW'({OUT_CNT_BITS{1'b1}})) ?
                          {OUT_CNT_BITS{1'b1}} : cnt_ext[OUT_CNT_BITS-1:0];
  assign found_o        = out_found_q;
  assign last_o         = out_last_q;

  `BPVAM_ASSERT(a_res_from_sweep, result_valid_o |-> ($past(state_q) == ST_SWEEP || $past(state_q) == ST_DRAIN || $past(state_q) == ST_FLUSH), "result outside finish run")
  `BPVAM_ASSERT(a_empty_is_last, (result_valid_o && !found_o) |-> last_o, "empty result not last")
  `BPVAM_ASSERT(a_last_ends_run, (result_valid_o && last_o) |-> (state_q == ST_IDLE), "last result while busy")
  `BPVAM_ASSERT(a_flush_to_idle, (state_q == ST_FLUSH) |=> (state_q == ST_IDLE), "flush did not return to idle")
  `BPVAM_NEVER(a_no_idle_write, (state_q == ST_IDLE) && we, "table write while idle")

endmodule
